// File: sv/gaps_pkg.sv
// Package for the grid path search block: item codes, status codes,
// register indexes and fixed widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gaps_pkg;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;
  localparam int SCORE_W    = 16;
  localparam logic [31:0] SCORE_LIMIT = 32'd65535;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BLOCKED = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam logic [1:0] MODE_EUCLID  = 2'd0;
  localparam logic [1:0] MODE_SQUARED = 2'd1;

  // Neighbour order of the expansion.
  localparam logic [1:0] DIR_YINC = 2'd0;
  localparam logic [1:0] DIR_YDEC = 2'd1;
  localparam logic [1:0] DIR_XINC = 2'd2;
  localparam logic [1:0] DIR_XDEC = 2'd3;

  localparam logic [6:0] RST_WIDTH  = 7'd64;
  localparam logic [6:0] RST_HEIGHT = 7'd64;
  localparam logic [1:0] RST_MODE   = 2'd2;

endpackage
`default_nettype wire

// File: sv/gaps_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gaps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/gaps_heur.sv
// Heuristic unit: Manhattan, squared or floored Euclidean distance, the
// square root taken one result bit per cycle. Depends on gaps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gaps_heur #(
  parameter int CW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [1:0]    mode,
  input  wire logic [CW-1:0] x,
  input  wire logic [CW-1:0] y,
  input  wire logic [CW-1:0] gx,
  input  wire logic [CW-1:0] gy,
  output logic               done,
  output logic [2*CW:0]      h
);

  localparam int HW = 2 * CW + 1;
  localparam int RW = (HW + 1) / 2;
  localparam int IW = $clog2(RW + 1);
  localparam logic [HW-1:0] BIT_FIRST = HW'(1) << (2 * (RW - 1));

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_MUL  = 4'b0010,
    H_ROOT = 4'b0100,
    H_DONE = 4'b1000
  } hstate_t;

  hstate_t         state;
  logic [CW-1:0]   dx, dy;
  logic [HW-1:0]   rem, root, bitm;
  logic [IW-1:0]   iter;
  logic [2*CW-1:0] pdx, pdy;
  logic [HW-1:0]   sq;
  logic [HW:0]     trial;
  logic            take;
  logic [HW-1:0]   root_next;

  assign pdx = (2*CW)'(dx) * (2*CW)'(dx);
  assign pdy = (2*CW)'(dy) * (2*CW)'(dy);
  assign sq  = HW'(pdx) + HW'(pdy);

  assign trial     = {1'b0, root} + {1'b0, bitm};
  assign take      = {1'b0, rem} >= trial;
  assign root_next = take ? ((root >> 1) + bitm) : (root >> 1);

  assign done = (state == H_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
    end else begin
      case (state)
        H_IDLE: begin
          if (start) begin
            dx    <= (x > gx) ? x - gx : gx - x;
            dy    <= (y > gy) ? y - gy : gy - y;
            state <= H_MUL;
          end
        end
        H_MUL: begin
          if (mode == gaps_pkg::MODE_EUCLID) begin
            rem   <= sq;
            root  <= '0;
            bitm  <= BIT_FIRST;
            iter  <= IW'(RW);
            state <= H_ROOT;
          end else begin
            h     <= (mode == gaps_pkg::MODE_SQUARED) ? sq : HW'(dx) + HW'(dy);
            state <= H_DONE;
          end
        end
        H_ROOT: begin
          if (take) begin
            rem <= rem - trial[HW-1:0];
          end
          root <= root_next;
          bitm <= bitm >> 2;
          iter <= iter - IW'(1);
          if (iter == IW'(1)) begin
            h     <= root_next;
            state <= H_DONE;
          end
        end
        H_DONE: begin
          state <= H_IDLE;
        end
        default: begin
          state <= H_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/grid_astar_path_search_top.sv
// Top level of the four-connected grid path search: stream ports, register
// port, search sequencer. Depends on gaps_pkg, gaps_ram and gaps_heur.
`timescale 1ns / 1ps
`default_nettype none
// Usage
// Items arrive on the s_axis channel and every item gives exactly one result
// transaction on the m_axis channel carrying a two-bit status. A write item
// stores one cell's walkability, a read item checks an index against the
// length of the stored path, and a search item runs A* from the start cell
// to the goal cell, keeping only the length of the path it finds.
// Registers (width, height, distance mode) are written over the cfg channel,
// which is always ready; they should only change while the block is idle.
// Sequence: write, read and unknown items pass through the finish state to the
// result register, and a new item is accepted only once the previous one has
// left the finish state. A search first checks both endpoints (states RS, RG
// and RGW), then clears the visited memory, one cell per cycle, and then
// loops: each expansion scans the open list memory one entry per cycle and
// probes up to four neighbours, each fresh one waiting for the heuristic
// unit, with its square-root iterations in floored Euclidean mode. The scan
// of the open list bounds the search time.
// Reset returns the registers to 64, 64 and Manhattan, empties the stored
// path and clears pending results; map contents are undefined until written.
// When the receiver stalls, the result waits in the output register and the
// next item is still accepted; a following result waits until that one goes.
module grid_astar_path_search_top #(
  parameter int MAX_COLUMNS  = 64,
  parameter int MAX_ROWS     = 64,
  parameter int INVALID_CODE = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // From bit 0: action[2], cell_x[6], cell_y[6], walk_value[8], goal_x[6],
  // goal_y[6], path_index[12], two zero bits.
  input  wire logic [gaps_pkg::IN_DATA_W-1:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // From bit 0: status[2], six zero bits.
  output logic [gaps_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);

  localparam int CELLS  = MAX_COLUMNS * MAX_ROWS;
  localparam int AW     = $clog2(CELLS);
  localparam int MAXDIM = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
  localparam int CW     = $clog2(MAXDIM);
  localparam int GW     = AW + 1;
  localparam int HW     = 2 * CW + 1;
  localparam int SW     = gaps_pkg::SCORE_W;
  localparam int EW     = 1 + 2 * CW + GW + SW;

  // Sequencer states.
  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_RS   = 13'b0000000000010,
    S_RG   = 13'b0000000000100,
    S_RGW  = 13'b0000000001000,
    S_CLR  = 13'b0000000010000,
    S_INIT = 13'b0000000100000,
    S_IW   = 13'b0000001000000,
    S_SCAN = 13'b0000010000000,
    S_PICK = 13'b0000100000000,
    S_NB   = 13'b0001000000000,
    S_NBW  = 13'b0010000000000,
    S_HW   = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_t;

  state_t state;

  // Unpacked input fields.
  logic [1:0]  in_action;
  logic [5:0]  in_cell_x, in_cell_y, in_goal_x, in_goal_y;
  logic [7:0]  in_walk_value;
  logic [11:0] in_path_index;

  assign in_action     = s_axis_tdata[1:0];
  assign in_cell_x     = s_axis_tdata[7:2];
  assign in_cell_y     = s_axis_tdata[13:8];
  assign in_walk_value = s_axis_tdata[21:14];
  assign in_goal_x     = s_axis_tdata[27:22];
  assign in_goal_y     = s_axis_tdata[33:28];
  assign in_path_index = s_axis_tdata[45:34];

  // Registers.
  logic [6:0] map_width, map_height;
  logic [1:0] distance_mode;

  assign cfg_ready = 1'b1;

  // Search context.
  logic [GW-1:0] path_len;
  logic [CW-1:0] sx, sy, gx, gy, cx, cy, nb_x, nb_y;
  logic [AW-1:0] st_addr, gl_addr, nb_addr, clr_i;
  logic [GW-1:0] cur_g;
  logic [1:0]    dir;
  logic          st_walk;
  logic [AW:0]   list_count, scan_i;
  logic [AW-1:0] rd_idx;
  logic          rd_vld;
  logic          found;
  logic [AW-1:0] best_idx;
  logic [CW-1:0] best_x, best_y;
  logic [GW-1:0] best_g;
  logic [SW-1:0] best_score;
  logic [1:0]    res_status;

  logic in_acc;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] ax,
                                               input logic [CW-1:0] ay);
    logic [31:0] full;
    full = 32'(ay) * 32'(MAX_COLUMNS) + 32'(ax);
    return full[AW-1:0];
  endfunction

  // Grid test on nine-bit coordinates against the columns and rows in use.
  logic [8:0] grid_w, grid_h;
  assign grid_w = {2'b00, map_width};
  assign grid_h = {2'b00, map_height};

  function automatic logic col_ok(input logic [8:0] v, input logic [8:0] w);
    return (v < w) && (v < 9'(MAX_COLUMNS));
  endfunction

  function automatic logic row_ok(input logic [8:0] v, input logic [8:0] w);
    return (v < w) && (v < 9'(MAX_ROWS));
  endfunction

  logic start_in, goal_in;
  assign start_in = col_ok(9'(in_cell_x), grid_w) && row_ok(9'(in_cell_y), grid_h);
  assign goal_in  = col_ok(9'(in_goal_x), grid_w) && row_ok(9'(in_goal_y), grid_h);

  // Neighbour of the cell being expanded in the current direction.
  logic [8:0] nxw, nyw;
  logic       nb_under, nb_ok;
  always_comb begin
    nxw      = 9'(cx);
    nyw      = 9'(cy);
    nb_under = 1'b0;
    case (dir)
      gaps_pkg::DIR_YINC: nyw = 9'(cy) + 9'd1;
      gaps_pkg::DIR_YDEC: begin
        nb_under = (cy == '0);
        nyw      = 9'(cy) - 9'd1;
      end
      gaps_pkg::DIR_XINC: nxw = 9'(cx) + 9'd1;
      default: begin
        nb_under = (cx == '0);
        nxw      = 9'(cx) - 9'd1;
      end
    endcase
    nb_ok = !nb_under && col_ok(nxw, grid_w) && row_ok(nyw, grid_h);
  end

  logic [AW-1:0] nb_addr_c;
  assign nb_addr_c = cell_addr(CW'(nxw), CW'(nyw));

  // Walkability map: one bit per cell.
  logic          walk_we, walk_rdata;
  logic [AW-1:0] walk_waddr, walk_raddr;
  logic          walk_wdata;

  assign walk_we = in_acc && (in_action == gaps_pkg::ACT_WRITE) &&
                   (9'(in_cell_x) < 9'(MAX_COLUMNS)) && (9'(in_cell_y) < 9'(MAX_ROWS));
  assign walk_waddr = cell_addr(CW'(in_cell_x), CW'(in_cell_y));
  assign walk_wdata = (in_walk_value != 8'd0) && (in_walk_value != 8'(INVALID_CODE));
  assign walk_raddr = (state == S_RS) ? st_addr : (state == S_RG) ? gl_addr : nb_addr_c;

  gaps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_walk (
    .clk(clk), .we(walk_we), .waddr(walk_waddr), .wdata(walk_wdata),
    .raddr(walk_raddr), .rdata(walk_rdata)
  );

  // Heuristic unit.
  logic          heur_start, heur_done;
  logic [HW-1:0] heur_h;
  logic [CW-1:0] hx, hy;
  logic          nb_fresh;

  // Visited marks: a cell is marked when the search starts from it or first reaches it as a walkable neighbour.
  logic          seen_we, seen_wdata, seen_rdata;
  logic [AW-1:0] seen_waddr;

  assign nb_fresh   = (state == S_NBW) && walk_rdata && !seen_rdata;
  assign heur_start = (state == S_INIT) || nb_fresh;
  assign hx         = (state == S_INIT) ? sx : nb_x;
  assign hy         = (state == S_INIT) ? sy : nb_y;

  gaps_heur #(.CW(CW)) u_heur (
    .clk(clk), .rst(rst), .start(heur_start), .mode(distance_mode),
    .x(hx), .y(hy), .gx(gx), .gy(gy), .done(heur_done), .h(heur_h)
  );

  assign seen_we    = (state == S_CLR) || (state == S_INIT) || nb_fresh;
  assign seen_waddr = (state == S_CLR) ? clr_i : (state == S_INIT) ? st_addr : nb_addr;
  assign seen_wdata = (state != S_CLR);

  gaps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_seen (
    .clk(clk), .we(seen_we), .waddr(seen_waddr), .wdata(seen_wdata),
    .raddr(nb_addr_c), .rdata(seen_rdata)
  );

  // Open list in insertion order: live, x, y, g, score.
  logic [GW-1:0] new_g;
  logic [31:0]   new_score;
  logic          new_ok;

  assign new_g     = (state == S_IW) ? '0 : cur_g + GW'(1);
  assign new_score = 32'(new_g) + 32'(heur_h);
  assign new_ok    = new_score < gaps_pkg::SCORE_LIMIT;

  logic          list_we;
  logic [AW-1:0] list_waddr;
  logic [EW-1:0] list_wdata, list_rdata;
  logic          e_live;
  logic [CW-1:0] e_x, e_y;
  logic [GW-1:0] e_g;
  logic [SW-1:0] e_score;

  assign list_we = ((state == S_IW || state == S_HW) && heur_done && new_ok) ||
                   ((state == S_PICK) && found);
  assign list_waddr = (state == S_PICK) ? best_idx : list_count[AW-1:0];
  assign list_wdata = (state == S_PICK) ?
                      {1'b0, best_x, best_y, best_g, best_score} :
                      {1'b1, (state == S_IW) ? sx : nb_x, (state == S_IW) ? sy : nb_y,
                       new_g, new_score[SW-1:0]};

  gaps_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_list (
    .clk(clk), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
    .raddr(scan_i[AW-1:0]), .rdata(list_rdata)
  );

  assign e_score = list_rdata[SW-1:0];
  assign e_g     = list_rdata[SW +: GW];
  assign e_y     = list_rdata[SW+GW +: CW];
  assign e_x     = list_rdata[SW+GW+CW +: CW];
  assign e_live  = list_rdata[EW-1];

  logic scan_more;
  assign scan_more = scan_i < list_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      path_len      <= '0;
      list_count    <= '0;
      scan_i        <= '0;
      rd_vld        <= 1'b0;
      found         <= 1'b0;
      map_width     <= gaps_pkg::RST_WIDTH;
      map_height    <= gaps_pkg::RST_HEIGHT;
      distance_mode <= gaps_pkg::RST_MODE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gaps_pkg::REG_WIDTH:  map_width     <= cfg_data;
          gaps_pkg::REG_HEIGHT: map_height    <= cfg_data;
          gaps_pkg::REG_MODE:   distance_mode <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            sx      <= CW'(in_cell_x);
            sy      <= CW'(in_cell_y);
            gx      <= CW'(in_goal_x);
            gy      <= CW'(in_goal_y);
            st_addr <= cell_addr(CW'(in_cell_x), CW'(in_cell_y));
            gl_addr <= cell_addr(CW'(in_goal_x), CW'(in_goal_y));
            res_status <= gaps_pkg::ST_OK;
            state      <= S_FIN;
            case (in_action)
              gaps_pkg::ACT_SEARCH: begin
                if (start_in && goal_in) begin
                  state <= S_RS;
                end else begin
                  res_status <= gaps_pkg::ST_BLOCKED;
                end
              end
              gaps_pkg::ACT_READ: begin
                res_status <= (32'(in_path_index) < 32'(path_len)) ?
                              gaps_pkg::ST_OK : gaps_pkg::ST_RANGE;
              end
              default: ;
            endcase
          end
        end
        S_RS: state <= S_RG;
        S_RG: begin
          st_walk <= walk_rdata;
          state   <= S_RGW;
        end
        S_RGW: begin
          if (st_walk && walk_rdata) begin
            clr_i <= '0;
            state <= S_CLR;
          end else begin
            res_status <= gaps_pkg::ST_BLOCKED;
            state      <= S_FIN;
          end
        end
        S_CLR: begin
          clr_i <= clr_i + AW'(1);
          if (clr_i == AW'(CELLS - 1)) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          path_len   <= '0;
          list_count <= '0;
          scan_i     <= '0;
          state      <= S_IW;
        end
        S_IW: begin
          if (heur_done) begin
            if (new_ok) begin
              list_count <= list_count + (AW+1)'(1);
            end
            scan_i <= '0;
            rd_vld <= 1'b0;
            found  <= 1'b0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_vld <= scan_more;
          rd_idx <= scan_i[AW-1:0];
          if (scan_more) begin
            scan_i <= scan_i + (AW+1)'(1);
          end
          // Later entries win ties, so the most recent insertion is chosen.
          if (rd_vld && e_live && (!found || e_score <= best_score)) begin
            found      <= 1'b1;
            best_idx   <= rd_idx;
            best_x     <= e_x;
            best_y     <= e_y;
            best_g     <= e_g;
            best_score <= e_score;
          end
          if (!scan_more && !rd_vld) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          if (!found) begin
            path_len   <= '0;
            res_status <= gaps_pkg::ST_OK;
            state      <= S_FIN;
          end else if (best_x == gx && best_y == gy) begin
            path_len   <= best_g + GW'(1);
            res_status <= gaps_pkg::ST_OK;
            state      <= S_FIN;
          end else begin
            cx    <= best_x;
            cy    <= best_y;
            cur_g <= best_g;
            dir   <= gaps_pkg::DIR_YINC;
            state <= S_NB;
          end
        end
        S_NB: begin
          if (nb_ok) begin
            nb_x    <= CW'(nxw);
            nb_y    <= CW'(nyw);
            nb_addr <= nb_addr_c;
            state   <= S_NBW;
          end else if (dir == gaps_pkg::DIR_XDEC) begin
            scan_i <= '0;
            rd_vld <= 1'b0;
            found  <= 1'b0;
            state  <= S_SCAN;
          end else begin
            dir <= dir + 2'd1;
          end
        end
        S_NBW: begin
          if (nb_fresh) begin
            state <= S_HW;
          end else if (dir == gaps_pkg::DIR_XDEC) begin
            scan_i <= '0;
            rd_vld <= 1'b0;
            found  <= 1'b0;
            state  <= S_SCAN;
          end else begin
            dir   <= dir + 2'd1;
            state <= S_NB;
          end
        end
        S_HW: begin
          if (heur_done) begin
            if (new_ok) begin
              list_count <= list_count + (AW+1)'(1);
            end
            if (dir == gaps_pkg::DIR_XDEC) begin
              scan_i <= '0;
              rd_vld <= 1'b0;
              found  <= 1'b0;
              state  <= S_SCAN;
            end else begin
              dir   <= dir + 2'd1;
              state <= S_NB;
            end
          end
        end
        S_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid     <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {(gaps_pkg::OUT_DATA_W-2)'(0), res_status};
    end
  end

  // Checks on the sequencer.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted without leaving idle");

  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    list_count <= (AW+1)'(CELLS))
    else $error("open list longer than the grid");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan_i <= list_count)
    else $error("scan beyond the open list");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_FIN))
    else $error("result raised outside the finish state");

endmodule
`default_nettype wire
